// ----- hdl/mos_pkg.sv -----
// Package for the median-of-sample-set block: sizes, status codes, FSM states.
// No dependencies; imported by median_of_sample_set_core.
`timescale 1ns / 1ps

package mos_pkg;

  localparam int DEPTH       = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int MED_W       = SAMPLE_BITS + 1;
  localparam int STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CAND,
    S_SCAN,
    S_EVAL,
    S_SUM
  } state_t;

endpackage

// ----- hdl/mos_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/median_of_sample_set_core.sv -----
// Top level of the median-of-sample-set block: sample memory, rank-select FSM.
// Depends on mos_pkg and mos_ram.
`timescale 1ns / 1ps

// Usage:
//   An item is transferred at a rising edge with start high and busy low.
//   in_op = push stores in_sample (signed Q23.8) in the sample memory; a push
//   gives no result and leaves busy low. Pushes beyond DEPTH are dropped and
//   flagged. in_op = finish reports the median of the held samples and
//   clears the set.
//   Finish selects the median by rank: stored samples are taken in turn as
//   candidates until both middle ranks are found, and for each the whole set is
//   scanned once through the single read port of the sample memory, counting
//   smaller and equal samples. busy stays high until the selection is done and
//   drops in the cycle the result strobe out_valid is shown; an empty finish
//   shows its result in the cycle after it is taken and leaves busy low.
//   out_median_doubled is twice the median (sum of the two middle samples
//   for an even count), out_status gives ok / empty / overflow and
//   out_sample_count the number of held samples.
//   Each result is shown for exactly one cycle; the receiver cannot stall.
//   Reset (synchronous, rst_n low) empties the set and clears the overflow
//   flag; memory contents are left as they are and are never read unwritten.
module median_of_sample_set_core
  import mos_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_op,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  output logic [MED_W-1:0]       out_median_doubled,
  output logic [STATUS_W-1:0]    out_status,
  output logic [CNT_W-1:0]       out_sample_count
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [ADDR_W-1:0]      i_r, i_nxt;
  logic [ADDR_W-1:0]      j_r, j_nxt;
  logic [CNT_W-1:0]       lt_r, lt_nxt;
  logic [CNT_W-1:0]       eq_r, eq_nxt;
  logic [CNT_W-1:0]       k0_r, k0_nxt;
  logic [CNT_W-1:0]       k1_r, k1_nxt;
  logic                   f0_r, f0_nxt;
  logic                   f1_r, f1_nxt;
  logic [SAMPLE_BITS-1:0] cand_r, cand_nxt;
  logic [SAMPLE_BITS-1:0] v0_r, v0_nxt;
  logic [SAMPLE_BITS-1:0] v1_r, v1_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [MED_W-1:0]       med_r, med_nxt;
  status_t                status_r, status_nxt;
  logic [CNT_W-1:0]       ocount_r, ocount_nxt;

  logic                   accept;
  logic                   is_finish;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [ADDR_W-1:0]      last_idx;
  logic [CNT_W-1:0]       mid;
  logic [CNT_W-1:0]       hi_rank;
  logic                   hit0, hit1;
  logic                   scan_last;
  logic                   sel_done;

  assign accept    = start && !busy;
  assign is_finish = (in_op == OP_FINISH);
  assign last_idx  = ADDR_W'(count_r - CNT_W'(1));
  assign scan_last = (j_r == last_idx);
  assign mid       = count_r >> 1;
  assign hi_rank   = CNT_W'(lt_r + eq_r);
  // candidate covers ranks [lt, lt+eq) of the sorted set
  assign hit0      = (lt_r <= k0_r) && (k0_r < hi_rank);
  assign hit1      = (lt_r <= k1_r) && (k1_r < hi_rank);
  assign sel_done  = (f0_r || hit0) && (f1_r || hit1);

  mos_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && is_finish && (count_r != '0)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_CAND;
      S_CAND: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: state_nxt = sel_done ? S_SUM : S_LOAD;
      S_SUM:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_raddr = i_r;
    case (state_r)
      S_IDLE: begin
        busy   = 1'b0;
        ram_we = start && !is_finish && (count_r < CNT_W'(DEPTH));
      end
      S_LOAD:  ram_raddr = i_r;
      S_CAND:  ram_raddr = '0;
      S_SCAN:  ram_raddr = ADDR_W'(j_r + ADDR_W'(1));
      default: ram_raddr = i_r;
    endcase
  end

  // datapath
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lt_nxt        = lt_r;
    eq_nxt        = eq_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    f0_nxt        = f0_r;
    f1_nxt        = f1_r;
    cand_nxt      = cand_r;
    v0_nxt        = v0_r;
    v1_nxt        = v1_r;
    out_valid_nxt = 1'b0;
    med_nxt       = med_r;
    status_nxt    = status_r;
    ocount_nxt    = ocount_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !is_finish) begin
          if (count_r < CNT_W'(DEPTH)) begin
            count_nxt = CNT_W'(count_r + CNT_W'(1));
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (accept) begin
          if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            med_nxt       = '0;
            status_nxt    = ST_EMPTY;
            ocount_nxt    = '0;
            ovf_nxt       = 1'b0;
          end else begin
            i_nxt  = '0;
            f0_nxt = 1'b0;
            f1_nxt = 1'b0;
            k1_nxt = mid;
            k0_nxt = count_r[0] ? mid : CNT_W'(mid - CNT_W'(1));
          end
        end
      end
      S_CAND: begin
        cand_nxt = ram_rdata;
        j_nxt    = '0;
        lt_nxt   = '0;
        eq_nxt   = '0;
      end
      S_SCAN: begin
        if ($signed(ram_rdata) < $signed(cand_r)) begin
          lt_nxt = CNT_W'(lt_r + CNT_W'(1));
        end else if (ram_rdata == cand_r) begin
          eq_nxt = CNT_W'(eq_r + CNT_W'(1));
        end
        j_nxt = ADDR_W'(j_r + ADDR_W'(1));
      end
      S_EVAL: begin
        if (hit0) begin
          f0_nxt = 1'b1;
          v0_nxt = cand_r;
        end
        if (hit1) begin
          f1_nxt = 1'b1;
          v1_nxt = cand_r;
        end
        i_nxt = ADDR_W'(i_r + ADDR_W'(1));
      end
      S_SUM: begin
        out_valid_nxt = 1'b1;
        med_nxt       = {v0_r[SAMPLE_BITS-1], v0_r} + {v1_r[SAMPLE_BITS-1], v1_r};
        status_nxt    = ovf_r ? ST_OVERFLOW : ST_OK;
        ocount_nxt    = count_r;
        count_nxt     = '0;
        ovf_nxt       = 1'b0;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    lt_r     <= lt_nxt;
    eq_r     <= eq_nxt;
    k0_r     <= k0_nxt;
    k1_r     <= k1_nxt;
    f0_r     <= f0_nxt;
    f1_r     <= f1_nxt;
    cand_r   <= cand_nxt;
    v0_r     <= v0_nxt;
    v1_r     <= v1_nxt;
    med_r    <= med_nxt;
    status_r <= status_nxt;
    ocount_r <= ocount_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = med_r;
  assign out_status         = status_r;
  assign out_sample_count   = ocount_r;

  // a result always leaves the set cleared
  a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r == '0) && !ovf_r)
    else $error("set not cleared after result");

  // results are only shown while the block is idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result shown while busy");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_EMPTY)) |-> (med_r == '0) && (ocount_r == '0))
    else $error("empty result carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("held count exceeds depth");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (hi_rank <= count_r) && (eq_r != '0))
    else $error("rank counters out of range");

endmodule
